@@ src/tfd_pkg.sv @@
package tfd_pkg;

  // 2*pi in Q.28 and 0.02 in Q.32
  localparam logic [30:0]        TWO_PI_Q28      = 31'd1686629713;
  localparam logic signed [27:0] NOISE_SCALE_Q32 = 28'sd85899346;

  // Cutoff mapping: fc = 800 Hz + 11200 Hz * filter_amount, in Q.16 Hz
  localparam logic [29:0] FC_MIN_Q16      = 30'd52428800;
  localparam logic [13:0] FC_SPAN_HZ      = 14'd11200;
  localparam logic [17:0] DEFAULT_RATE_HZ = 18'd44100;

  // Configuration register indexes
  localparam logic [1:0] CFG_FILTER_AMOUNT = 2'd0;
  localparam logic [1:0] CFG_NOISE_AMOUNT  = 2'd1;
  localparam logic [1:0] CFG_FEEDBACK_GAIN = 2'd2;
  localparam logic [1:0] CFG_SAMPLE_RATE   = 2'd3;

  // Control from the top level to the sample path
  typedef struct packed {
    logic start;
    logic drain_ok;
  } smp_req_t;

  // Status from the sample path to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } smp_rsp_t;

  // Unsigned 64-bit long division, one quotient bit per loop pass. Used at
  // elaboration only, to build constant tables.
  function automatic logic [63:0] long_div64(input logic [63:0] num,
                                             input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    int          i;
    q = 64'd0;
    r = 65'd0;
    for (i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-x) with x and result in Q.32. Evaluated at elaboration only, to
  // build constant tables; the run-time version is the serial unit.
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
    logic [63:0]        y;
    logic [63:0]        t;
    logic [63:0]        e;
    logic signed [63:0] s;
    int                 n;
    int                 k;
    if (x >= 64'h0000_0010_0000_0000) begin
      return 64'd0;
    end
    y = x >> 4;
    t = 64'h0000_0001_0000_0000;
    s = 64'sh0000_0001_0000_0000;
    for (n = 1; n <= 12; n++) begin
      t = long_div64((t * y) >> 32, 64'(n));
      if (n[0] == 1'b1) begin
        s = s - $signed(t);
      end else begin
        s = s + $signed(t);
      end
    end
    if (s < 0) begin
      s = 64'sd0;
    end
    if (s > 64'sh0000_0000_FFFF_FFFF) begin
      s = 64'sh0000_0000_FFFF_FFFF;
    end
    e = $unsigned(s);
    for (k = 0; k < 4; k++) begin
      e = (e * e + 64'h8000_0000) >> 32;
    end
    return e;
  endfunction

endpackage

@@ src/tfd_if.sv @@
interface tfd_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [15:0]                   random_word;

  modport source (output valid, output sample_in, output random_word, input ready);
  modport sink (input valid, input sample_in, input random_word, output ready);
endinterface

interface tfd_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

@@ src/tfd_coef.sv @@
// Bit-serial lowpass coefficient unit: alpha = 1 - exp(-2*pi*fc/fs).
// One shift-add multiplier step or one restoring divider step per cycle.
module tfd_coef
  import tfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [15:0] filter_amount,
  input  logic [17:0] sample_rate_hz,
  output logic        busy,
  output logic [15:0] alpha
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MUL1 = 3'd1;
  localparam logic [2:0] C_DIV1 = 3'd2;
  localparam logic [2:0] C_TMUL = 3'd3;
  localparam logic [2:0] C_TDIV = 3'd4;
  localparam logic [2:0] C_SQ   = 3'd5;
  localparam logic [2:0] C_FIN  = 3'd6;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  logic [2:0]         state;
  logic [5:0]         cnt;
  logic [63:0]        acc;
  logic [63:0]        mcand;
  logic [31:0]        mplier;
  logic [63:0]        dq;
  logic [17:0]        rem;
  logic [17:0]        divisor;
  logic [31:0]        y;
  logic signed [34:0] s;
  logic [31:0]        e;
  logic [3:0]         n;
  logic [1:0]         sq;

  logic [63:0]        acc_add;
  logic [63:0]        acc_rnd;
  logic [18:0]        rem_sh;
  logic [18:0]        rem_sub;
  logic               ge;
  logic [17:0]        rem_n;
  logic [63:0]        dq_n;
  logic [31:0]        tq;
  logic signed [34:0] s_n;
  logic [31:0]        s_clamp;
  logic [29:0]        fc_q16;
  logic [17:0]        fs_eff;
  logic [32:0]        e_rnd;
  logic [16:0]        a_full;

  assign acc_add = acc + (mplier[0] ? mcand : 64'd0);
  assign acc_rnd = acc_add + 64'h8000_0000;

  assign rem_sh  = {rem, dq[63]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign rem_n   = ge ? rem_sub[17:0] : rem_sh[17:0];
  assign dq_n    = {dq[62:0], ge};

  assign tq  = dq_n[31:0];
  assign s_n = n[0] ? (s - $signed({3'b000, tq})) : (s + $signed({3'b000, tq}));

  always_comb begin
    if (s_n[34]) begin
      s_clamp = 32'd0;
    end else if (s_n[33:32] != 2'b00) begin
      s_clamp = 32'hFFFF_FFFF;
    end else begin
      s_clamp = s_n[31:0];
    end
  end

  assign fc_q16 = FC_MIN_Q16 + 30'(FC_SPAN_HZ * filter_amount);
  assign fs_eff = (sample_rate_hz == 18'd0) ? DEFAULT_RATE_HZ : sample_rate_hz;

  assign e_rnd  = {1'b0, e} + 33'd32768;
  assign a_full = 17'h1_0000 - e_rnd[32:16];

  assign busy = (state != C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else if (go) begin
      acc     <= 64'd0;
      mcand   <= {33'd0, TWO_PI_Q28};
      mplier  <= {2'b00, fc_q16};
      divisor <= fs_eff;
      cnt     <= 6'd0;
      state   <= C_MUL1;
    end else begin
      unique case (state)
        C_IDLE: begin
          state <= C_IDLE;
        end
        C_MUL1: begin
          acc    <= acc_add;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            dq    <= acc_add;
            rem   <= 18'd0;
            cnt   <= 6'd0;
            state <= C_DIV1;
          end
        end
        C_DIV1: begin
          rem <= rem_n;
          dq  <= dq_n;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            cnt <= 6'd0;
            // Exponent of 16 or more gives exp(-x) = 0.
            if (dq_n[63:48] != 16'd0) begin
              e     <= 32'd0;
              state <= C_FIN;
            end else begin
              y      <= dq_n[47:16];
              s      <= $signed({2'b00, ONE_Q32});
              n      <= 4'd1;
              acc    <= 64'd0;
              mcand  <= {31'd0, ONE_Q32};
              mplier <= dq_n[47:16];
              state  <= C_TMUL;
            end
          end
        end
        C_TMUL: begin
          acc    <= acc_add;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            dq      <= {acc_add[63:32], 32'd0};
            rem     <= 18'd0;
            divisor <= {14'd0, n};
            cnt     <= 6'd0;
            state   <= C_TDIV;
          end
        end
        C_TDIV: begin
          rem <= rem_n;
          dq  <= dq_n;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            s   <= s_n;
            cnt <= 6'd0;
            acc <= 64'd0;
            if (n == 4'd12) begin
              e      <= s_clamp;
              mcand  <= {32'd0, s_clamp};
              mplier <= s_clamp;
              sq     <= 2'd0;
              state  <= C_SQ;
            end else begin
              n      <= n + 4'd1;
              mcand  <= {32'd0, tq};
              mplier <= y;
              state  <= C_TMUL;
            end
          end
        end
        C_SQ: begin
          acc    <= acc_add;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            e   <= acc_rnd[63:32];
            cnt <= 6'd0;
            if (sq == 2'd3) begin
              state <= C_FIN;
            end else begin
              sq     <= sq + 2'd1;
              acc    <= 64'd0;
              mcand  <= {32'd0, acc_rnd[63:32]};
              mplier <= acc_rnd[63:32];
            end
          end
        end
        C_FIN: begin
          alpha <= a_full[16] ? 16'hFFFF : a_full[15:0];
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/tfd_sample.sv @@
// Per-sample path: lowpass, tanh table, quantizer with a bit-serial
// divider, noise and gain.
module tfd_sample
  import tfd_pkg::*;
#(
  parameter int SAMPLE_BITS      = 16,
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int LVL_W            = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smp_req_t                      req,
  output smp_rsp_t                      rsp,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [15:0]                   random_word,
  input  logic [15:0]                   alpha,
  input  logic [15:0]                   noise_amount,
  input  logic [15:0]                   feedback_gain,
  input  logic [LVL_W-1:0]              level_count,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int SH    = 24 - SAMPLE_BITS;
  localparam int DW    = $clog2(TANH_TABLE_DEPTH);
  localparam int HALF2 = (SH > 0) ? (1 << (SH - 1)) : 0;

  localparam logic signed [28:0] OUT_HI = 29'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [28:0] OUT_LO = -OUT_HI - 29'sd1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FILT = 4'd1;
  localparam logic [3:0] S_MEM  = 4'd2;
  localparam logic [3:0] S_POS  = 4'd3;
  localparam logic [3:0] S_TAB  = 4'd4;
  localparam logic [3:0] S_INT  = 4'd5;
  localparam logic [3:0] S_NRM  = 4'd6;
  localparam logic [3:0] S_QNT  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_GAIN = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  function automatic logic [TANH_TABLE_DEPTH*16-1:0] build_tanh();
    logic [TANH_TABLE_DEPTH*16-1:0] rom;
    logic [63:0]                    mag;
    logic [63:0]                    yy;
    logic [63:0]                    ee;
    logic [63:0]                    num;
    logic [63:0]                    den;
    logic [63:0]                    tt;
    logic [15:0]                    tv;
    int                             i;
    int                             d;
    for (i = 0; i < TANH_TABLE_DEPTH; i++) begin
      d   = 2 * i - (TANH_TABLE_DEPTH - 1);
      mag = 64'((d < 0) ? -d : d);
      yy  = long_div64(mag << 33, 64'(TANH_TABLE_DEPTH - 1));
      ee  = exp_neg_q32(yy);
      num = (64'h0000_0001_0000_0000 - ee) << 15;
      den = 64'h0000_0001_0000_0000 + ee;
      tt  = long_div64(num + (den >> 1), den);
      tv  = tt[15:0];
      rom[i*16 +: 16] = (d < 0) ? (16'd0 - tv) : tv;
    end
    return rom;
  endfunction

  localparam logic [TANH_TABLE_DEPTH*16-1:0] TANH_ROM = build_tanh();

  logic [3:0]                    state;
  logic [4:0]                    cnt;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [15:0]                   rw;
  logic signed [23:0]            mem;
  logic signed [41:0]            prod;
  logic signed [34:0]            nz1;
  logic signed [60:0]            nz2;
  logic signed [19:0]            nterm;
  logic [DW-1:0]                 idx;
  logic [23:0]                   frac;
  logic signed [15:0]            ta;
  logic signed [15:0]            tb;
  logic [24:0]                   nval;
  logic [LVL_W-1:0]              rem;
  logic [24:0]                   dq;
  logic signed [43:0]            gp;

  logic signed [24:0]            s25;
  logic signed [24:0]            diff;
  logic signed [17:0]            nz;
  logic signed [41:0]            prod_b;
  logic signed [26:0]            newm;
  logic signed [60:0]            nz2_b;
  logic [23:0]                   u;
  logic [24+DW-1:0]              pos;
  logic signed [16:0]            tdif;
  logic signed [26:0]            v;
  logic signed [26:0]            nraw;
  logic [LVL_W-1:0]              lm1;
  logic [24+LVL_W:0]             qp;
  logic [24+LVL_W-1:0]           dvd;
  logic [LVL_W:0]                rem_sh;
  logic                          ge;
  logic [LVL_W:0]                rem_sub;
  logic signed [26:0]            v2;
  logic signed [43:0]            gp_b;
  logic signed [28:0]            r1;
  logic signed [28:0]            r1_b;
  logic signed [28:0]            r2;

  assign s25  = $signed({{(25 - SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp}) <<< SH;
  assign diff = s25 - $signed({mem[23], mem});
  assign nz   = $signed({1'b0, rw, 1'b0}) - 18'sd65536;

  // Rounding half away from zero: add half, or half minus one when negative.
  assign prod_b = prod + (prod[41] ? 42'sh7FFF : 42'sh8000);
  assign newm   = $signed({{3{mem[23]}}, mem})
                + $signed({prod_b[41], prod_b[41:16]});
  assign nz2_b  = nz2 + (nz2[60] ? 61'sh0FF_FFFF_FFFF : 61'sh100_0000_0000);

  assign u   = {~mem[23], mem[22:0]};
  assign pos = u * DW'(TANH_TABLE_DEPTH - 1);

  assign tdif = $signed({tb[15], tb}) - $signed({ta[15], ta});
  assign v    = $signed({{3{ta[15]}}, ta, 8'd0})
              + $signed({prod_b[41], prod_b[41:16]});
  assign nraw = v + 27'sd8388608;

  assign lm1     = level_count - LVL_W'(1);
  assign qp      = (LVL_W + 25)'(nval * lm1) + (LVL_W + 25)'(24'h80_0000);
  assign dvd     = {qp[24 +: LVL_W], 24'd0} + (24 + LVL_W)'(lm1 >> 1);
  assign rem_sh  = {rem, dq[24]};
  assign ge      = (rem_sh >= {1'b0, lm1});
  assign rem_sub = rem_sh - {1'b0, lm1};

  assign v2 = $signed({2'b00, dq}) - 27'sd8388608 + $signed({{7{nterm[19]}}, nterm});

  assign gp_b = gp + (gp[43] ? 44'sh3FFF : 44'sh4000);
  assign r1   = gp_b[43:15];
  assign r1_b = r1 + ((SH == 0) ? 29'sd0 : (r1[28] ? 29'(HALF2 - 1) : 29'(HALF2)));
  assign r2   = r1_b >>> SH;

  always_comb begin
    if (r2 > OUT_HI) begin
      result = OUT_HI[SAMPLE_BITS-1:0];
    end else if (r2 < OUT_LO) begin
      result = OUT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = r2[SAMPLE_BITS-1:0];
    end
  end

  assign rsp.busy = (state != S_IDLE);
  assign rsp.done = (state == S_OUT) && req.drain_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mem   <= 24'sd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            smp   <= sample_in;
            rw    <= random_word;
            state <= S_FILT;
          end
        end
        S_FILT: begin
          prod  <= $signed({1'b0, alpha}) * diff;
          nz1   <= nz * $signed({1'b0, noise_amount});
          state <= S_MEM;
        end
        S_MEM: begin
          if (newm > 27'sd8388607) begin
            mem <= 24'sh7F_FFFF;
          end else if (newm < -27'sd8388608) begin
            mem <= 24'sh80_0000;
          end else begin
            mem <= newm[23:0];
          end
          nz2   <= 61'(nz1 * NOISE_SCALE_Q32);
          state <= S_POS;
        end
        S_POS: begin
          idx   <= pos[24 +: DW];
          frac  <= pos[23:0];
          nterm <= nz2_b[60:41];
          state <= S_TAB;
        end
        S_TAB: begin
          ta    <= TANH_ROM[idx*16 +: 16];
          tb    <= TANH_ROM[(idx + DW'(1))*16 +: 16];
          state <= S_INT;
        end
        S_INT: begin
          prod  <= 42'(tdif * $signed({1'b0, frac}));
          state <= S_NRM;
        end
        S_NRM: begin
          if (nraw < 27'sd0) begin
            nval <= 25'd0;
          end else if (nraw > 27'sd16777216) begin
            nval <= 25'h100_0000;
          end else begin
            nval <= nraw[24:0];
          end
          state <= S_QNT;
        end
        S_QNT: begin
          // The quotient stays below 2^25, so the bits above 25 start the
          // partial remainder.
          rem   <= {1'b0, dvd[24+LVL_W-1:25]};
          dq    <= dvd[24:0];
          cnt   <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? rem_sub[LVL_W-1:0] : rem_sh[LVL_W-1:0];
          dq  <= {dq[23:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd24) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          gp    <= v2 * $signed({1'b0, feedback_gain});
          state <= S_OUT;
        end
        S_OUT: begin
          if (req.drain_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/tape_feedback_degrader_unit.sv @@
// Feedback-path degrader for a tape-style delay line.
// Input channel in_ch carries one audio sample (signed Q1.15 at the default
// width) and one uniform random word per transfer; output channel out_ch
// returns one processed sample per input transfer, in order.
// Each sample goes through a one-pole lowpass, a tanh soft clip from a
// constant table, a quantizer, optional noise and the feedback gain, and is
// saturated to the sample width.
// One sample is in flight at a time. The result is registered, and the next
// input is taken once the sample path is idle again at the earliest. The
// quantizer's restoring divider resolves one of 25 quotient bits per cycle.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata. A write
// to the filter amount or the sample rate starts a run of the serial
// coefficient unit, during which no input is taken. The same run follows
// reset, after which the registers hold their reset values and the filter
// memory is zero.
// A stalled receiver holds the result in the output register; the sample
// path waits on its final step, while the input side may still take the
// next transfer once the sample path is free.
module tape_feedback_degrader_unit
  import tfd_pkg::*;
#(
  parameter int SAMPLE_BITS      = 16,
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int MAX_LEVELS       = 256
) (
  input  logic        clk,
  input  logic        rst,
  tfd_in_if.sink      in_ch,
  tfd_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_wdata
);

  localparam int LVL_W = $clog2(MAX_LEVELS + 1);

  // Configuration registers
  logic [15:0]      filter_amount;
  logic [15:0]      noise_amount;
  logic [15:0]      feedback_gain;
  logic [17:0]      sample_rate_hz;
  logic [LVL_W-1:0] level_count;
  logic [LVL_W-1:0] level_count_next;
  logic [28:0]      level_span;

  // Coefficient start request; set by reset so alpha follows the reset values.
  logic             coef_go;
  logic             coef_busy;
  logic [15:0]      alpha;

  smp_req_t         smp_req;
  smp_rsp_t         smp_rsp;
  logic signed [SAMPLE_BITS-1:0] smp_result;

  // Output register
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_data;

  logic in_xfer;

  // Level count: 2 + (MAX_LEVELS-2)*(1 - noise_amount), floored.
  assign level_span = 29'(MAX_LEVELS - 2) * (29'h1_0000 - 29'(cfg_wdata[15:0]));
  assign level_count_next = LVL_W'(level_span[28:16]) + LVL_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_amount  <= 16'd0;
      noise_amount   <= 16'd0;
      feedback_gain  <= 16'h8000;
      sample_rate_hz <= DEFAULT_RATE_HZ;
      level_count    <= LVL_W'(MAX_LEVELS);
      coef_go        <= 1'b1;
    end else begin
      coef_go <= 1'b0;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FILTER_AMOUNT: begin
            filter_amount <= cfg_wdata[15:0];
            coef_go       <= 1'b1;
          end
          CFG_NOISE_AMOUNT: begin
            noise_amount <= cfg_wdata[15:0];
            level_count  <= level_count_next;
          end
          CFG_FEEDBACK_GAIN: begin
            feedback_gain <= cfg_wdata[15:0];
          end
          CFG_SAMPLE_RATE: begin
            sample_rate_hz <= cfg_wdata;
            coef_go        <= 1'b1;
          end
          default: begin
            coef_go <= 1'b0;
          end
        endcase
      end
    end
  end

  tfd_coef u_coef (
    .clk            (clk),
    .rst            (rst),
    .go             (coef_go),
    .filter_amount  (filter_amount),
    .sample_rate_hz (sample_rate_hz),
    .busy           (coef_busy),
    .alpha          (alpha)
  );

  // The sample path takes a new transfer whenever it and the coefficient
  // unit are free; a waiting output does not hold the input back.
  assign in_ch.ready = !smp_rsp.busy && !coef_busy && !coef_go;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign smp_req.start    = in_xfer;
  assign smp_req.drain_ok = !out_valid || out_ch.ready;

  tfd_sample #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
    .LVL_W            (LVL_W)
  ) u_sample (
    .clk           (clk),
    .rst           (rst),
    .req           (smp_req),
    .rsp           (smp_rsp),
    .sample_in     (in_ch.sample_in),
    .random_word   (in_ch.random_word),
    .alpha         (alpha),
    .noise_amount  (noise_amount),
    .feedback_gain (feedback_gain),
    .level_count   (level_count),
    .result        (smp_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (smp_rsp.done) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_rsp.done) begin
      out_data <= smp_result;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_data;

  // A finished sample is released only into a free or draining output slot.
  assert property (@(posedge clk) disable iff (rst)
    smp_rsp.done |-> (!out_valid || out_ch.ready))
    else $error("sample released into an occupied output register");

  // An input transfer always starts the sample path.
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> smp_rsp.busy)
    else $error("input transfer did not start the sample path");

  // No input is taken while the coefficient is being recomputed.
  assert property (@(posedge clk) disable iff (rst)
    coef_busy |-> !in_xfer)
    else $error("input taken during coefficient update");

  // The level count stays within the quantizer's range.
  assert property (@(posedge clk) disable iff (rst)
    (level_count >= LVL_W'(2)) && (level_count <= LVL_W'(MAX_LEVELS)))
    else $error("level count out of range");

endmodule
